// ===== design/spc_pkg.sv =====
// Shared package of the simple polygon check block.
// Holds the sizing constants, the vertex and crossing status types, the state and
// tag codes and a helper function. Depends on nothing.
package spc_pkg;

    // Store and coordinate sizing.
    localparam int MAX_VERTICES = 64;
    localparam int COORD_WIDTH  = 24;
    localparam int MIN_VERTICES = 3;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int NUM_CCW      = 4;

    // One stored vertex.
    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
    } t_point;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_EDGE,
        ST_PAIR,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // What a memory read returns: the fixed edge of the outer loop or another
    // edge to test against it.
    typedef enum logic {
        TAG_EDGE,
        TAG_PAIR
    } t_rd_tag;

    // Status from the crossing pipeline back to the sequencer.
    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } t_cross_status;

    // Exact difference of two signed coordinates, one bit wider.
    function automatic logic signed [DIFF_W-1:0] coord_diff(
        input logic [COORD_WIDTH-1:0] p,
        input logic [COORD_WIDTH-1:0] q
    );
        return $signed({p[COORD_WIDTH-1], p}) - $signed({q[COORD_WIDTH-1], q});
    endfunction

endpackage

// ===== design/spc_ifs.sv =====
// Valid/ready channel interfaces of the simple polygon check block.
// Depends on spc_pkg for the coordinate width.
interface spc_vertex_if;
    logic                                valid;
    logic                                ready;
    logic signed [spc_pkg::COORD_WIDTH-1:0] vertex_x;
    logic signed [spc_pkg::COORD_WIDTH-1:0] vertex_y;
    logic                                last_vertex;

    modport source (output valid, output vertex_x, output vertex_y,
                    output last_vertex, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y,
                    input last_vertex, output ready);
endinterface

interface spc_result_if;
    logic valid;
    logic ready;
    logic is_simple;
    logic overflowed;

    modport source (output valid, output is_simple, output overflowed, input ready);
    modport sink   (input valid, input is_simple, input overflowed, output ready);
endinterface

// ===== design/spc_cross_pipe.sv =====
// Pipelined edge crossing test: differences, products, then compare.
// Takes one edge pair per cycle and flags a strict crossing out of the compare stage register.
// Depends on spc_pkg.
module spc_cross_pipe (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  spc_pkg::t_point        i_a,
    input  spc_pkg::t_point        i_b,
    input  spc_pkg::t_point        i_c,
    input  spc_pkg::t_point        i_d,
    output spc_pkg::t_cross_status o_status
);
    import spc_pkg::*;

    t_point p1 [NUM_CCW];
    t_point p2 [NUM_CCW];
    t_point p3 [NUM_CCW];

    logic signed [DIFF_W-1:0] r_la [NUM_CCW];
    logic signed [DIFF_W-1:0] r_lb [NUM_CCW];
    logic signed [DIFF_W-1:0] r_ra [NUM_CCW];
    logic signed [DIFF_W-1:0] r_rb [NUM_CCW];
    logic signed [PROD_W-1:0] r_lhs [NUM_CCW];
    logic signed [PROD_W-1:0] r_rhs [NUM_CCW];
    logic [NUM_CCW-1:0]       gt;
    logic                     r_hit;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;

    // The four orientation tests: (A,C,D), (B,C,D), (A,B,C) and (A,B,D).
    always_comb begin
        p1[0] = i_a; p2[0] = i_c; p3[0] = i_d;
        p1[1] = i_b; p2[1] = i_c; p3[1] = i_d;
        p1[2] = i_a; p2[2] = i_b; p3[2] = i_c;
        p1[3] = i_a; p2[3] = i_b; p3[3] = i_d;
    end

    // Stage one: the coordinate differences of every test.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_CCW; k++) begin
            r_la[k] <= coord_diff(p3[k].y, p1[k].y);
            r_lb[k] <= coord_diff(p2[k].x, p1[k].x);
            r_ra[k] <= coord_diff(p2[k].y, p1[k].y);
            r_rb[k] <= coord_diff(p3[k].x, p1[k].x);
        end
    end

    // Stage two: the exact products of both sides.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_CCW; k++) begin
            r_lhs[k] <= r_la[k] * r_lb[k];
            r_rhs[k] <= r_ra[k] * r_rb[k];
        end
    end

    // Stage three: strict comparison and the crossing rule.
    always_comb begin
        for (int k = 0; k < NUM_CCW; k++) begin
            gt[k] = r_lhs[k] > r_rhs[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= (gt[0] != gt[1]) && (gt[2] != gt[3]);
    end

    // Valid bits that follow each pair down the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_status.busy      = r_v1 | r_v2 | r_v3;
    assign o_status.hit_valid = r_v3;
    assign o_status.hit       = r_hit;

endmodule

// ===== design/simple_polygon_check_core.sv =====
// Top level of the simple polygon check block.
// Depends on spc_pkg, spc_ifs (channel interfaces) and spc_cross_pipe.
//
// Vertices are loaded one per cycle, while the block is in its load state,
// into a 64-entry vertex memory; the transaction that carries last_vertex
// closes the polygon. For n stored vertices the block then walks every pair
// of non-adjacent edges, the wrap edge included: each outer edge takes one
// fetch and each edge pair one fetch, since the memory's two read ports
// deliver one pair of vertices a cycle. After the walk the block waits for
// the read register and the crossing pipeline to drain, then loads the
// result register once the output is free. A polygon of fewer than three
// vertices skips the walk and goes straight to the finish state. No vertex
// is taken during the walk; loading of the next polygon may start while the
// previous result still waits at the output. Vertices beyond 64 are dropped
// and reported through overflowed. The memory needs no clearing after reset.
module simple_polygon_check_core (
    input logic          i_clk,
    input logic          i_rst_n,
    spc_vertex_if.sink   i_vertex,
    spc_result_if.source o_result
);
    import spc_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_i;
    logic [CNT_W-1:0]    n_i;
    logic [CNT_W-1:0]    r_j;
    logic [CNT_W-1:0]    n_j;
    logic                r_ovf;
    logic                r_ovf_res;
    logic                r_crossed;
    logic                r_rd_valid;
    t_rd_tag             r_rd_tag;
    t_point              r_rd_a;
    t_point              r_rd_b;
    t_point              r_pa;
    t_point              r_pb;
    logic                r_out_valid;
    logic                r_out_simple;
    logic                r_out_ovf;

    t_point              mem [MAX_VERTICES];

    logic                in_accept;
    logic                close;
    logic                store_full;
    logic [CNT_W-1:0]    cnt_after;
    logic [CNT_W-1:0]    i_plus1;
    logic [CNT_W-1:0]    i_plus2;
    logic [CNT_W-1:0]    j_plus1;
    logic [CNT_W-1:0]    j_next;
    logic [CNT_W-1:0]    j_last;
    logic [CNT_W-1:0]    i_last;
    logic                has_pairs;
    logic                out_free;
    logic                pipe_idle;
    logic                rd_en;
    t_rd_tag             rd_tag;
    logic [IDX_W-1:0]    rd_addr_a;
    logic [IDX_W-1:0]    rd_addr_b;
    logic                in_ready;
    logic                out_load;
    t_cross_status       cross_st;

    // Handshake and loop bound arithmetic.
    assign in_accept  = i_vertex.valid && in_ready;
    assign close      = in_accept && i_vertex.last_vertex;
    assign store_full = (r_count == CNT_W'(MAX_VERTICES));
    assign cnt_after  = store_full ? r_count : r_count + CNT_W'(1);
    assign i_plus1    = r_i + CNT_W'(1);
    assign i_plus2    = r_i + CNT_W'(2);
    assign j_plus1    = r_j + CNT_W'(1);
    assign j_next     = (r_j == r_n - CNT_W'(1)) ? '0 : j_plus1;
    assign j_last     = (r_i == '0) ? r_n - CNT_W'(2) : r_n - CNT_W'(1);
    assign i_last     = r_n - CNT_W'(MIN_VERTICES);
    assign has_pairs  = (i_plus2 <= j_last);
    assign out_free   = !r_out_valid || o_result.ready;
    assign pipe_idle  = !r_rd_valid && !cross_st.busy;

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (close) begin
                    n_state = (cnt_after >= CNT_W'(MIN_VERTICES)) ? ST_EDGE : ST_FINISH;
                end
            end
            ST_EDGE: begin
                if (has_pairs) begin
                    n_state = ST_PAIR;
                end else if (r_i == i_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_PAIR: begin
                if (r_j == j_last) begin
                    n_state = (r_i == i_last) ? ST_DRAIN : ST_EDGE;
                end
            end
            ST_DRAIN: begin
                if (pipe_idle) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Sequencer: read requests, loop counters and handshake outputs.
    always_comb begin
        rd_en     = 1'b0;
        rd_tag    = TAG_EDGE;
        rd_addr_a = '0;
        rd_addr_b = '0;
        n_i       = r_i;
        n_j       = r_j;
        in_ready  = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                in_ready = 1'b1;
                if (i_vertex.valid && i_vertex.last_vertex) begin
                    n_i = '0;
                end
            end
            ST_EDGE: begin
                rd_en     = 1'b1;
                rd_tag    = TAG_EDGE;
                rd_addr_a = r_i[IDX_W-1:0];
                rd_addr_b = i_plus1[IDX_W-1:0];
                n_j       = i_plus2;
                if (!has_pairs && r_i != i_last) begin
                    n_i = i_plus1;
                end
            end
            ST_PAIR: begin
                rd_en     = 1'b1;
                rd_tag    = TAG_PAIR;
                rd_addr_a = r_j[IDX_W-1:0];
                rd_addr_b = j_next[IDX_W-1:0];
                if (r_j == j_last) begin
                    n_i = i_plus1;
                end else begin
                    n_j = j_plus1;
                end
            end
            ST_DRAIN: begin
                out_load = 1'b0;
            end
            ST_FINISH: begin
                out_load = out_free;
            end
            default: out_load = 1'b0;
        endcase
    end

    // Vertex memory: one write port for loading, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (in_accept && !store_full) begin
            mem[r_count[IDX_W-1:0]] <= t_point'{x: i_vertex.vertex_x, y: i_vertex.vertex_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_a <= mem[rd_addr_a];
            r_rd_b <= mem[rd_addr_b];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_crossed   <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_en;
            if (close) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (in_accept) begin
                if (store_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (close) begin
                r_crossed <= 1'b0;
            end else if (cross_st.hit_valid && cross_st.hit) begin
                r_crossed <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: loop state, fixed outer edge and the result.
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_rd_tag <= rd_tag;
        if (close) begin
            r_n       <= cnt_after;
            r_ovf_res <= r_ovf | store_full;
        end
        if (r_rd_valid && r_rd_tag == TAG_EDGE) begin
            r_pa <= r_rd_a;
            r_pb <= r_rd_b;
        end
        if (out_load) begin
            r_out_simple <= (r_n >= CNT_W'(MIN_VERTICES)) && !r_crossed;
            r_out_ovf    <= r_ovf_res;
        end
    end

    // Crossing test of the fixed edge against each fetched edge.
    spc_cross_pipe u_cross_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_valid && r_rd_tag == TAG_PAIR),
        .i_a      (r_pa),
        .i_b      (r_pb),
        .i_c      (r_rd_a),
        .i_d      (r_rd_b),
        .o_status (cross_st)
    );

    assign i_vertex.ready      = in_ready;
    assign o_result.valid      = r_out_valid;
    assign o_result.is_simple  = r_out_simple;
    assign o_result.overflowed = r_out_ovf;

endmodule

// ===== design/spc_checker.sv =====
// Port-level assertions of the simple polygon check block.
// Holds the checker module and the bind that attaches it to the top level.
module spc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_last,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_simple,
    input logic i_out_ovf
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_simple)
            && $stable(i_out_ovf))
        else $error("result changed while stalled");

    // Closing a polygon stops loading until its result is built.
    a_busy_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("vertex input still ready after polygon closed");

    // A new result only appears when loading was held off just before its rise.
    a_result_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a closing walk");

    // Reset leaves an empty output and a loading input.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("wrong state after reset");

endmodule

bind simple_polygon_check_core spc_checker u_spc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_vertex.valid),
    .i_in_ready   (i_vertex.ready),
    .i_in_last    (i_vertex.last_vertex),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_simple (o_result.is_simple),
    .i_out_ovf    (o_result.overflowed)
);
